// ----- hdl/hbk_pkg.sv -----
// shared types, constants and character lookup for the keyboard edge detector
`timescale 1ns / 1ps

package hbk_pkg;

    localparam int KEY_SLOTS_DEF = 6;

    localparam logic [7:0] MOD_USAGE    = 8'hE0;
    localparam logic [7:0] SHIFT_MASK   = 8'h22;
    localparam logic [7:0] ROLLOVER_MAX = 8'h03;
    localparam logic [7:0] CHAR_BASE    = 8'h04;
    localparam logic [7:0] CHAR_COUNT   = 8'h35;
    localparam logic [7:0] LETTER_COUNT = 8'd26;
    localparam logic [3:0] MIN_LENGTH   = 4'd3;

    localparam logic [1:0] EDGE_UP   = 2'd0;
    localparam logic [1:0] EDGE_DOWN = 2'd1;
    localparam logic [1:0] EDGE_NONE = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_LEN  = 2'd1;
    localparam logic [1:0] STAT_ROLLOVER = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MOD_UP,
        ST_KEY_UP,
        ST_MOD_DN,
        ST_KEY_DN,
        ST_SUMMARY
    } state_t;

    typedef enum logic [1:0] {
        PH_MOD_UP,
        PH_KEY_UP,
        PH_MOD_DN,
        PH_KEY_DN
    } phase_t;

    typedef struct packed {
        logic   capture;
        logic   clr_idx;
        logic   step;
        logic   emit;
        logic   summary;
        logic   commit;
        phase_t phase;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic idx_done;
        logic out_free;
        logic bad_len;
        logic rollover;
    } status_t;

    // non-letter keys starting at usage 0x1e, unshifted
    localparam logic [6:0] PLAIN_REST [27] = '{
        7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
        7'h0A, 7'h1B, 7'h08, 7'h09, 7'h20,
        7'h2D, 7'h3D, 7'h5B, 7'h5D, 7'h5C,
        7'h00,
        7'h3B, 7'h27, 7'h60, 7'h2C, 7'h2E, 7'h2F
    };

    localparam logic [6:0] SHIFT_REST [27] = '{
        7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29,
        7'h0A, 7'h1B, 7'h08, 7'h09, 7'h20,
        7'h5F, 7'h2B, 7'h7B, 7'h7D, 7'h7C,
        7'h00,
        7'h3A, 7'h22, 7'h7E, 7'h3C, 7'h3E, 7'h3F
    };

    function automatic logic [6:0] char_lookup(input logic [7:0] usage, input logic shift);
        logic [7:0] off;
        logic [7:0] rest;
        logic [6:0] ch;
        off  = usage - CHAR_BASE;
        rest = off - LETTER_COUNT;
        if (usage < CHAR_BASE || usage >= CHAR_BASE + CHAR_COUNT)
        begin
            ch = 7'h00;
        end
        else if (off < LETTER_COUNT)
        begin
            ch = (shift ? 7'h41 : 7'h61) + off[6:0];
        end
        else
        begin
            ch = shift ? SHIFT_REST[rest[4:0]] : PLAIN_REST[rest[4:0]];
        end
        return ch;
    endfunction

endpackage

// ----- hdl/hbk_datapath.sv -----
// report registers, previous-report state, edge compare and output register
`timescale 1ns / 1ps

module hbk_datapath #(
    parameter int KEY_SLOTS = hbk_pkg::KEY_SLOTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [63:0]      in_data,
    input  hbk_pkg::cmd_t    cmd,
    output hbk_pkg::status_t status,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [23:0]      m_axis_tdata,
    output logic [1:0]       m_axis_tuser,
    output logic             m_axis_tlast
);
    import hbk_pkg::*;

    logic [7:0] mods_reg;
    logic [7:0] cur_reg [KEY_SLOTS];
    logic [7:0] prev_mods_reg;
    logic [7:0] prev_keys_reg [KEY_SLOTS];
    logic       bad_len_reg;
    logic       rollover_reg;
    logic [2:0] idx_reg;
    logic [4:0] count_reg;

    logic       out_valid_reg;
    logic [1:0] out_kind_reg;
    logic [7:0] out_usage_reg;
    logic [6:0] out_char_reg;
    logic       out_last_reg;
    logic [1:0] out_status_reg;
    logic [4:0] out_count_reg;

    logic [7:0] slot_in [KEY_SLOTS];
    logic [3:0] len_in;
    logic       roll_in;
    logic [7:0] cur_sel;
    logic [7:0] prev_sel;
    logic       cur_has_prev;
    logic       prev_has_cur;
    logic       hit;
    logic [1:0] kind;
    logic [7:0] usage;
    logic [6:0] ch;
    logic       out_free;

    // masked slots and rollover check at capture
    always_comb
    begin
        len_in  = in_data[59:56];
        roll_in = 1'b0;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            slot_in[i] = (4'(2 + i) < len_in) ? in_data[8*(i+1) +: 8] : 8'h00;
            if (slot_in[i] != 8'h00 && slot_in[i] <= ROLLOVER_MAX)
            begin
                roll_in = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mods_reg     <= in_data[7:0];
            cur_reg      <= slot_in;
            bad_len_reg  <= len_in < MIN_LENGTH;
            rollover_reg <= roll_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_mods_reg <= '0;
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                prev_keys_reg[i] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            prev_mods_reg <= mods_reg;
            prev_keys_reg <= cur_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.clr_idx || cmd.capture)
            begin
                idx_reg <= '0;
            end
            else if (cmd.step)
            begin
                idx_reg <= idx_reg + 3'd1;
            end
            if (cmd.capture)
            begin
                count_reg <= '0;
            end
            else if (cmd.emit && !cmd.summary)
            begin
                count_reg <= count_reg + 5'd1;
            end
        end
    end

    // slot under the scan index and its presence in the other report
    always_comb
    begin
        cur_sel      = 8'h00;
        prev_sel     = 8'h00;
        cur_has_prev = 1'b0;
        prev_has_cur = 1'b0;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            if (idx_reg == 3'(i))
            begin
                cur_sel  = cur_reg[i];
                prev_sel = prev_keys_reg[i];
            end
        end
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            if (cur_reg[i] == prev_sel)
            begin
                cur_has_prev = 1'b1;
            end
            if (prev_keys_reg[i] == cur_sel)
            begin
                prev_has_cur = 1'b1;
            end
        end
    end

    always_comb
    begin
        hit   = 1'b0;
        kind  = EDGE_UP;
        usage = MOD_USAGE + {5'd0, idx_reg};
        ch    = 7'h00;
        unique case (cmd.phase)
            PH_MOD_UP:
            begin
                hit = prev_mods_reg[idx_reg] && !mods_reg[idx_reg];
            end
            PH_KEY_UP:
            begin
                hit   = prev_sel != 8'h00 && !cur_has_prev;
                usage = prev_sel;
            end
            PH_MOD_DN:
            begin
                hit  = !prev_mods_reg[idx_reg] && mods_reg[idx_reg];
                kind = EDGE_DOWN;
            end
            PH_KEY_DN:
            begin
                hit   = cur_sel != 8'h00 && !prev_has_cur;
                kind  = EDGE_DOWN;
                usage = cur_sel;
                ch    = char_lookup(cur_sel, (mods_reg & SHIFT_MASK) != 8'h00);
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
    end

    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (cmd.summary)
            begin
                out_kind_reg   <= EDGE_NONE;
                out_usage_reg  <= 8'h00;
                out_char_reg   <= 7'h00;
                out_last_reg   <= 1'b1;
                out_status_reg <= bad_len_reg  ? STAT_BAD_LEN  :
                                  rollover_reg ? STAT_ROLLOVER : STAT_OK;
                out_count_reg  <= count_reg;
            end
            else
            begin
                out_kind_reg   <= kind;
                out_usage_reg  <= usage;
                out_char_reg   <= ch;
                out_last_reg   <= 1'b0;
                out_status_reg <= STAT_OK;
                out_count_reg  <= 5'd0;
            end
        end
    end

    assign status.hit      = hit;
    assign status.idx_done = (cmd.phase == PH_MOD_UP || cmd.phase == PH_MOD_DN) ?
                             (idx_reg == 3'd7) : (idx_reg == 3'(KEY_SLOTS - 1));
    assign status.out_free = out_free;
    assign status.bad_len  = bad_len_reg;
    assign status.rollover = rollover_reg;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_count_reg, out_status_reg, out_char_reg, out_usage_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ----- hdl/hbk_ctrl.sv -----
// sequencer that walks a report through the release and press scans
`timescale 1ns / 1ps

module hbk_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  hbk_pkg::status_t status,
    output hbk_pkg::cmd_t    cmd
);
    import hbk_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   advance;

    // a scan step moves on unless an edge waits for the output register
    assign advance = !status.hit || status.out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = (status.bad_len || status.rollover) ? ST_SUMMARY : ST_MOD_UP;
            end
            ST_MOD_UP:
            begin
                if (advance && status.idx_done)
                begin
                    state_next = ST_KEY_UP;
                end
            end
            ST_KEY_UP:
            begin
                if (advance && status.idx_done)
                begin
                    state_next = ST_MOD_DN;
                end
            end
            ST_MOD_DN:
            begin
                if (advance && status.idx_done)
                begin
                    state_next = ST_KEY_DN;
                end
            end
            ST_KEY_DN:
            begin
                if (advance && status.idx_done)
                begin
                    state_next = ST_SUMMARY;
                end
            end
            ST_SUMMARY:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.clr_idx = 1'b0;
        cmd.step    = 1'b0;
        cmd.emit    = 1'b0;
        cmd.summary = 1'b0;
        cmd.commit  = 1'b0;
        cmd.phase   = PH_MOD_UP;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_CHECK:
            begin
                cmd.clr_idx = 1'b1;
            end
            ST_MOD_UP, ST_KEY_UP, ST_MOD_DN, ST_KEY_DN:
            begin
                cmd.phase   = (state_reg == ST_MOD_UP) ? PH_MOD_UP :
                              (state_reg == ST_KEY_UP) ? PH_KEY_UP :
                              (state_reg == ST_MOD_DN) ? PH_MOD_DN : PH_KEY_DN;
                cmd.step    = advance;
                cmd.clr_idx = advance && status.idx_done;
                cmd.emit    = status.hit && status.out_free;
            end
            ST_SUMMARY:
            begin
                cmd.summary = 1'b1;
                cmd.emit    = status.out_free;
                cmd.commit  = status.out_free && !status.bad_len && !status.rollover;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- hdl/hid_boot_keyboard_edge_detector.sv -----
// top level of the boot-protocol keyboard edge detector
`timescale 1ns / 1ps

// Takes one boot keyboard report per input transfer and compares it with the
// last accepted report: key-up edges come out first (modifier bits 0..7, then
// vanished keys), then key-down edges (modifier bits, then new keys with their
// US-layout ASCII), and every report closes with a tlast transfer carrying the
// status and edge count. A report with a length under 3 or a rollover code in
// a slot gives only the closing transfer and leaves the stored report alone.
// Reports are handled one at a time by a scan sequencer that checks one
// modifier bit or one key slot per cycle while no edge waits on a full
// output register. The next input transfer is taken only once the closing
// transfer of the current report has gone into the output register. A full
// output register stalls the scan only on cycles that produce an edge.
module hid_boot_keyboard_edge_detector #(
    parameter int KEY_SLOTS = hbk_pkg::KEY_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // modifier_bits, key_slot_0..key_slot_5, report_length, zero pad
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // key_usage, character, report_status, edge_count, zero pad
    output logic [23:0] m_axis_tdata,
    // edge_kind
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    import hbk_pkg::*;

    cmd_t    cmd;
    status_t status;

    hbk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hbk_datapath #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_data       (s_axis_tdata),
        .cmd           (cmd),
        .status        (status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ----- tb/hid_boot_keyboard_edge_detector_tb.sv -----
// self-checking testbench for the boot keyboard edge detector
`timescale 1ns / 1ps

module hid_boot_keyboard_edge_detector_tb;

    import hbk_pkg::*;

    localparam int SLOTS          = KEY_SLOTS_DEF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 64;

    // one keyboard report, packed the way it travels on s_axis_tdata
    typedef struct packed {
        logic [3:0]      len;
        logic [5:0][7:0] slots;
        logic [7:0]      mods;
    } report_t;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] usage;
        logic [6:0] ch;
        logic       last;
        logic [1:0] status;
        logic [4:0] count;
    } key_edge_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // modifier_bits, key_slot_0..key_slot_5, report_length, zero pad
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // key_usage, character, report_status, edge_count, zero pad
    logic [23:0] m_axis_tdata;
    // edge_kind
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    key_edge_t       pending_edges[$];
    logic [7:0]      held_mods;
    logic [5:0][7:0] held_keys;
    int              errors = 0;
    int              sender_idle_pct = 0;
    int              recv_stall_pct = 0;
    int              hold_request = 0;
    int              hold_left = 0;
    int              quiet_cycles = 0;
    key_edge_t       want;

    hid_boot_keyboard_edge_detector u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // US layout: letters computed, the rest looked up as {plain, shifted}
    function automatic logic [6:0] ascii_for(input logic [7:0] u, input bit shift);
        logic [15:0] pair;
        logic [7:0]  idx;
        pair = 16'h0000;
        idx  = u - CHAR_BASE;
        if (u >= CHAR_BASE && idx < 8'd26)
        begin
            pair = {8'h61 + idx, 8'h41 + idx};
        end
        else
        begin
            case (u)
                8'h1E: pair = {"1", "!"};
                8'h1F: pair = {"2", "@"};
                8'h20: pair = {"3", "#"};
                8'h21: pair = {"4", "$"};
                8'h22: pair = {"5", "%"};
                8'h23: pair = {"6", "^"};
                8'h24: pair = {"7", "&"};
                8'h25: pair = {"8", "*"};
                8'h26: pair = {"9", "("};
                8'h27: pair = {"0", ")"};
                8'h28: pair = {8'h0A, 8'h0A};
                8'h29: pair = {8'h1B, 8'h1B};
                8'h2A: pair = {8'h08, 8'h08};
                8'h2B: pair = {8'h09, 8'h09};
                8'h2C: pair = {" ", " "};
                8'h2D: pair = {"-", "_"};
                8'h2E: pair = {"=", "+"};
                8'h2F: pair = {"[", "{"};
                8'h30: pair = {"]", "}"};
                8'h31: pair = {8'h5C, "|"};
                8'h33: pair = {";", ":"};
                8'h34: pair = {"'", 8'h22};
                8'h35: pair = {8'h60, "~"};
                8'h36: pair = {",", "<"};
                8'h37: pair = {".", ">"};
                8'h38: pair = {"/", "?"};
                default: pair = 16'h0000;
            endcase
        end
        return shift ? pair[6:0] : pair[14:8];
    endfunction

    function automatic bit holds_usage(input logic [5:0][7:0] keys, input logic [7:0] u);
        for (int i = 0; i < 6; i++)
        begin
            if (keys[i] == u)
            begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic push_result(input logic [1:0] kind, input logic [7:0] usage,
                               input logic [6:0] ch, input logic last,
                               input logic [1:0] status, input logic [4:0] count);
        key_edge_t e;
        e.kind   = kind;
        e.usage  = usage;
        e.ch     = ch;
        e.last   = last;
        e.status = status;
        e.count  = count;
        pending_edges.push_back(e);
    endtask

    // works out the transfers one accepted report causes and updates the held report
    task automatic predict_key_edges(input report_t r);
        logic [5:0][7:0] cur;
        int              len;
        int              n;
        bit              shift;
        len = (r.len > 4'd8) ? 8 : int'(r.len);
        n   = 0;
        if (len < int'(MIN_LENGTH))
        begin
            push_result(EDGE_NONE, 8'h00, 7'h00, 1'b1, STAT_BAD_LEN, 5'd0);
            return;
        end
        for (int i = 0; i < 6; i++)
        begin
            cur[i] = (i >= SLOTS || 2 + i >= len) ? 8'h00 : r.slots[i];
        end
        for (int i = 0; i < 6; i++)
        begin
            if (cur[i] != 8'h00 && cur[i] <= ROLLOVER_MAX)
            begin
                push_result(EDGE_NONE, 8'h00, 7'h00, 1'b1, STAT_ROLLOVER, 5'd0);
                return;
            end
        end
        for (int i = 0; i < 8; i++)
        begin
            if (held_mods[i] && !r.mods[i])
            begin
                push_result(EDGE_UP, MOD_USAGE + 8'(i), 7'h00, 1'b0, STAT_OK, 5'd0);
                n++;
            end
        end
        for (int i = 0; i < 6; i++)
        begin
            if (held_keys[i] != 8'h00 && !holds_usage(cur, held_keys[i]))
            begin
                push_result(EDGE_UP, held_keys[i], 7'h00, 1'b0, STAT_OK, 5'd0);
                n++;
            end
        end
        for (int i = 0; i < 8; i++)
        begin
            if (!held_mods[i] && r.mods[i])
            begin
                push_result(EDGE_DOWN, MOD_USAGE + 8'(i), 7'h00, 1'b0, STAT_OK, 5'd0);
                n++;
            end
        end
        shift = (r.mods & SHIFT_MASK) != 8'h00;
        for (int i = 0; i < 6; i++)
        begin
            if (cur[i] != 8'h00 && !holds_usage(held_keys, cur[i]))
            begin
                push_result(EDGE_DOWN, cur[i], ascii_for(cur[i], shift), 1'b0, STAT_OK, 5'd0);
                n++;
            end
        end
        held_mods = r.mods;
        held_keys = cur;
        push_result(EDGE_NONE, 8'h00, 7'h00, 1'b1, STAT_OK, 5'(n));
    endtask

    task automatic send_report(input report_t r);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'h0, r};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        predict_key_edges(r);
    endtask

    // sender stops and waits for every expected transfer to come out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_edges.size() > 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic report_t mk(input logic [7:0] mods, input logic [7:0] k0,
                                   input logic [7:0] k1, input logic [7:0] k2,
                                   input logic [7:0] k3, input logic [7:0] k4,
                                   input logic [7:0] k5, input logic [3:0] len);
        report_t r;
        r.mods  = mods;
        r.slots = {k5, k4, k3, k2, k1, k0};
        r.len   = len;
        return r;
    endfunction

    function automatic logic [7:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
        begin
            return held_keys[$urandom_range(0, 5)];
        end
        else if (sel < 6)
        begin
            return 8'h00;
        end
        else if (sel < 9)
        begin
            return 8'($urandom_range(4, 8'h38));
        end
        return 8'($urandom_range(8'h39, 8'hFF));
    endfunction

    // mostly plausible reports that evolve from the held one, some raw noise
    function automatic report_t random_report();
        report_t r;
        if ($urandom_range(0, 99) < 85)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                r.mods = held_mods ^ ($urandom_range(0, 2) == 0 ? 8'h00
                                                             : 8'(1 << $urandom_range(0, 7)));
            end
            else
            begin
                r.mods = 8'($urandom);
            end
            for (int i = 0; i < 6; i++)
            begin
                r.slots[i] = pick_key();
            end
            r.len = ($urandom_range(0, 9) < 7) ? 4'd8 : 4'($urandom_range(3, 15));
        end
        else
        begin
            r.mods = 8'($urandom);
            for (int i = 0; i < 6; i++)
            begin
                r.slots[i] = 8'($urandom);
            end
            if ($urandom_range(0, 2) == 0)
            begin
                r.slots[$urandom_range(0, 5)] = 8'($urandom_range(1, 3));
            end
            r.len = 4'($urandom_range(0, 15));
        end
        return r;
    endfunction

    task automatic test_directed();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        send_report(mk(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 4'd8));
        // every modifier and six keys down together, shifted
        send_report(mk(8'hFF, 8'h04, 8'h1E, 8'h27, 8'h28, 8'h2C, 8'h38, 4'd8));
        send_report(mk(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 4'd8));
        send_report(mk(8'h02, 8'h1D, 8'h2D, 8'h31, 8'h34, 8'h35, 8'h32, 4'd8));
        send_report(mk(8'h20, 8'h1D, 8'h33, 8'h36, 8'h37, 8'h29, 8'h2A, 4'd8));
        send_report(mk(8'h00, 8'h33, 8'h2F, 8'h30, 8'h2B, 8'h2E, 8'h26, 4'd8));
        // short reports leave the held report alone
        send_report(mk(8'hFF, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 4'd0));
        send_report(mk(8'hAA, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'd1));
        send_report(mk(8'h55, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 4'd2));
        // slots past the length read as empty
        send_report(mk(8'h01, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F, 4'd3));
        send_report(mk(8'h80, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F, 4'd5));
        send_report(mk(8'h80, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F, 4'd7));
        send_report(mk(8'h40, 8'hFF, 8'hE0, 8'h39, 8'h32, 8'h00, 8'h66, 4'd15));
        send_report(mk(8'h40, 8'hFF, 8'hE0, 8'h39, 8'h32, 8'h00, 8'h66, 4'd9));
        // rollover codes in a live slot
        send_report(mk(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 4'd8));
        send_report(mk(8'h13, 8'h02, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 4'd8));
        send_report(mk(8'h00, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 4'd8));
        // rollover code beyond the length does not count
        send_report(mk(8'h00, 8'h05, 8'h06, 8'h07, 8'h00, 8'h00, 8'h01, 4'd7));
        // same usage in several slots
        send_report(mk(8'h00, 8'h10, 8'h10, 8'h10, 8'h00, 8'h11, 8'h11, 4'd8));
        send_report(mk(8'h22, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'd8));
        send_report(mk(8'hDD, 8'h04, 8'h1E, 8'h1F, 8'h2C, 8'h37, 8'h38, 4'd8));
        send_report(mk(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 4'd8));
        drain_results();
    endtask

    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        repeat (count)
        begin
            send_report(random_report());
        end
        drain_results();
    endtask

    task automatic test_idle_phases();
        test_random(120, 0, 0);
        test_random(120, 82, 0);
        test_random(120, 0, 82);
        test_random(120, 6, 6);
    endtask

    // receiver holds off while the sender keeps offering reports
    task automatic test_output_holdoff();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_request    = 600;
        repeat (12)
        begin
            send_report(random_report());
        end
        drain_results();
    endtask

    task automatic test_pause_drain();
        sender_idle_pct = 0;
        recv_stall_pct  = 30;
        repeat (4)
        begin
            send_report(random_report());
            send_report(random_report());
            drain_results();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    task automatic check_field(input string name, input int expv, input int act);
        if (expv != act)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, expv, act);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_edges.size() == 0)
            begin
                $error("output transfer with nothing expected: tdata %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                want = pending_edges.pop_front();
                check_field("edge_kind", want.kind, m_axis_tuser);
                check_field("key_usage", want.usage, m_axis_tdata[7:0]);
                check_field("character", want.ch, m_axis_tdata[14:8]);
                check_field("last_item", want.last, m_axis_tlast);
                check_field("report_status", want.status, m_axis_tdata[16:15]);
                check_field("edge_count", want.count, m_axis_tdata[21:17]);
            end
        end
    end

    // cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("Regression FAIL");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        held_mods = 8'h00;
        held_keys = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_idle_phases();
        test_output_holdoff();
        test_pause_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && pending_edges.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
